// ----- hdl/ohsp_pkg.sv -----
// ----------------------------------------------------------------------------
// OBU header and size parser package
// Shared types, codes and constants of the OBU header and size parser.
// ----------------------------------------------------------------------------
package ohsp_pkg;

    // Longest LEB128 field, in bytes.
    localparam int unsigned MAX_LEB_BYTES = 8;

    // Configuration register indexes.
    localparam int unsigned REG_ANNEXB_MODE = 0;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_AB_SIZE = 3'd1,
        PH_AB_HDR  = 3'd2,
        PH_AB_EXT  = 3'd3,
        PH_S5_HDR  = 3'd4,
        PH_S5_EXT  = 3'd5,
        PH_S5_SIZE = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_CORRUPT = 2'd1,
        ST_UNSUP   = 2'd2
    } t_status;

    // Header fields as held between bytes:
    // [3:0] type, [4] extension, [5] size flag, [8:6] temporal id, [10:9] spatial id.
    typedef logic [10:0] t_hdr_fields;

    // One step of the LEB128 decoder.
    typedef struct packed {
        logic [31:0] acc;   // low 32 bits of the decoded value
        logic        ovf;   // some bit at or above 2^32 is set
        logic [3:0]  cnt;   // bytes taken so far
        logic        done;  // field ended with a value that fits
        logic        err;   // field too long or value too large
    } t_leb;

    // One result of the parser.
    typedef struct packed {
        t_status     status;
        logic [3:0]  obu_kind;
        logic        ext_present;
        logic        size_present;
        logic [2:0]  tlayer;
        logic [1:0]  slayer;
        logic [1:0]  header_size;
        logic [31:0] body_len;
        logic [3:0]  used_len;
    } t_result;

    function automatic logic type_ok(input logic [3:0] t);
        return ((t >= 4'd1) && (t <= 4'd8)) || (t == 4'd15);
    endfunction

endpackage

// ----- hdl/ohsp_leb.sv -----
// ----------------------------------------------------------------------------
// LEB128 byte step
// Folds one byte into a running LEB128 value and flags its end or an error.
// ----------------------------------------------------------------------------
module ohsp_leb (
    input  logic [7:0]           i_byte,
    input  logic [31:0]          i_acc,
    input  logic                 i_ovf,
    input  logic [3:0]           i_cnt,
    output ohsp_pkg::t_leb       o_leb
);
    import ohsp_pkg::*;

    logic [5:0]  shamt;
    logic [55:0] shifted;
    logic [3:0]  cnt_inc;
    logic        ovf_n;

    // Each byte carries seven bits; the group index wraps at eight bytes.
    assign shamt   = 6'(i_cnt[2:0]) * 6'd7;
    assign shifted = {49'd0, i_byte[6:0]} << shamt;
    assign cnt_inc = i_cnt + 4'd1;
    assign ovf_n   = i_ovf | (|shifted[55:32]);

    always_comb begin
        o_leb.acc  = i_acc | shifted[31:0];
        o_leb.ovf  = ovf_n;
        o_leb.cnt  = cnt_inc;
        o_leb.done = !i_byte[7] && !ovf_n;
        o_leb.err  = i_byte[7] ? (cnt_inc >= 4'(MAX_LEB_BYTES)) : ovf_n;
    end

endmodule

// ----- hdl/ohsp_core.sv -----
// ----------------------------------------------------------------------------
// OBU parse core
// Parse state and the per-byte update of header, extension and size fields.
// ----------------------------------------------------------------------------
module ohsp_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_annexb,
    input  logic [7:0]           i_byte,
    input  logic                 i_sou,
    input  logic                 i_eod,
    output logic                 o_emit,
    output ohsp_pkg::t_result    o_result
);
    import ohsp_pkg::*;

    t_phase      r_phase, n_phase;
    logic [31:0] r_acc, n_acc;
    logic        r_ovf, n_ovf;
    logic [3:0]  r_cnt, n_cnt;
    logic [31:0] r_unit, n_unit;
    t_hdr_fields r_hf, n_hf;
    logic [1:0]  r_hc, n_hc;

    // State as seen by this byte: a start clears everything first.
    t_phase      ph0;
    logic [31:0] acc0;
    logic        ovf0;
    logic [3:0]  cnt0;
    logic [31:0] unit0;
    t_hdr_fields hf0;
    logic [1:0]  hc0;

    t_leb        leb;
    logic        hdr_done;
    logic        ab;
    t_status     st;
    logic [1:0]  hs;
    logic [31:0] pay;
    logic [3:0]  nread;

    always_comb begin
        if (i_sou) begin
            ph0   = i_annexb ? PH_AB_SIZE : PH_S5_HDR;
            acc0  = '0;
            ovf0  = 1'b0;
            cnt0  = '0;
            unit0 = '0;
            hf0   = '0;
            hc0   = '0;
        end else begin
            ph0   = r_phase;
            acc0  = r_acc;
            ovf0  = r_ovf;
            cnt0  = r_cnt;
            unit0 = r_unit;
            hf0   = r_hf;
            hc0   = r_hc;
        end
    end

    ohsp_leb u_leb (
        .i_byte (i_byte),
        .i_acc  (acc0),
        .i_ovf  (ovf0),
        .i_cnt  (cnt0),
        .o_leb  (leb)
    );

    always_comb begin
        n_phase  = ph0;
        n_acc    = acc0;
        n_ovf    = ovf0;
        n_cnt    = cnt0;
        n_unit   = unit0;
        n_hf     = hf0;
        n_hc     = hc0;
        o_emit   = 1'b0;
        st       = ST_OK;
        hs       = '0;
        pay      = '0;
        nread    = '0;
        hdr_done = 1'b0;
        ab       = (ph0 == PH_AB_HDR) || (ph0 == PH_AB_EXT);

        unique case (ph0)
            PH_AB_SIZE: begin
                n_acc = leb.acc;
                n_ovf = leb.ovf;
                n_cnt = leb.cnt;
                if (leb.err) begin
                    o_emit = 1'b1;
                    st     = ST_CORRUPT;
                end else if (leb.done) begin
                    n_unit  = leb.acc;
                    n_phase = PH_AB_HDR;
                end
            end
            PH_AB_HDR, PH_S5_HDR: begin
                n_hf = {5'd0, i_byte[1], i_byte[2], i_byte[6:3]};
                n_hc = 2'd1;
                if (i_byte[7] || !type_ok(i_byte[6:3])) begin
                    o_emit = 1'b1;
                    st     = ST_CORRUPT;
                end else if (!i_byte[1] && !ab) begin
                    o_emit = 1'b1;
                    st     = ST_UNSUP;
                end else if (i_byte[0]) begin
                    o_emit = 1'b1;
                    st     = ST_CORRUPT;
                end else if (i_byte[2]) begin
                    n_phase = ab ? PH_AB_EXT : PH_S5_EXT;
                end else begin
                    hdr_done = 1'b1;
                end
            end
            PH_AB_EXT, PH_S5_EXT: begin
                n_hf = {i_byte[4:3], i_byte[7:5], hf0[5:0]};
                n_hc = 2'd2;
                if (|i_byte[2:0]) begin
                    o_emit = 1'b1;
                    st     = ST_CORRUPT;
                end else begin
                    hdr_done = 1'b1;
                end
            end
            PH_S5_SIZE: begin
                n_acc = leb.acc;
                n_ovf = leb.ovf;
                n_cnt = leb.cnt;
                if (leb.err) begin
                    o_emit = 1'b1;
                    st     = ST_CORRUPT;
                end else if (leb.done) begin
                    o_emit = 1'b1;
                    hs     = hc0;
                    pay    = leb.acc;
                    nread  = leb.cnt + 4'(hc0);
                end
            end
            default: begin
            end
        endcase

        // Header complete: Annex B finishes here, section 5 goes on to the size.
        if (hdr_done) begin
            if (ab) begin
                o_emit = 1'b1;
                if (unit0 < 32'(n_hc)) begin
                    st = ST_CORRUPT;
                end else begin
                    hs    = n_hc;
                    pay   = unit0 - 32'(n_hc);
                    nread = cnt0 + 4'(n_hc);
                end
            end else begin
                n_phase = PH_S5_SIZE;
                n_acc   = '0;
                n_ovf   = 1'b0;
                n_cnt   = '0;
            end
        end

        // Data ran out with the unit still open.
        if (!o_emit && i_eod && (ph0 != PH_IDLE)) begin
            o_emit = 1'b1;
            st     = ST_CORRUPT;
        end

        if (o_emit) begin
            n_phase = PH_IDLE;
        end

        o_result.status       = st;
        o_result.obu_kind     = n_hf[3:0];
        o_result.ext_present  = n_hf[4];
        o_result.size_present = n_hf[5];
        o_result.tlayer       = n_hf[8:6];
        o_result.slayer       = n_hf[10:9];
        o_result.header_size  = hs;
        o_result.body_len     = pay;
        o_result.used_len     = nread;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else if (i_en) begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc  <= n_acc;
            r_ovf  <= n_ovf;
            r_cnt  <= n_cnt;
            r_unit <= n_unit;
            r_hf   <= n_hf;
            r_hc   <= n_hc;
        end
    end

    // A unit ends with its result: the parser then waits for the next start.
    a_idle_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && o_emit) |=> (r_phase == PH_IDLE))
        else $error("parser not idle after a result");

    // No state change without a byte being processed.
    a_phase_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(r_phase))
        else $error("parse phase moved without a byte");

    // The size field of a section 5 unit always follows a complete header.
    a_size_after_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_S5_SIZE) |-> (r_hc != 2'd0))
        else $error("size field reached without a header");

endmodule

// ----- hdl/obu_header_and_size_parser_unit.sv -----
// ----------------------------------------------------------------------------
// OBU header and size parser
// Parses one AV1 OBU header, optional extension byte and LEB128 size per unit.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Request contents
// s_axis    in         tdata: data_byte; tuser: start_of_unit; tlast: end_of_data
// m_axis    out        tdata: one parse result per unit (see port comment)
// APB       in         register 0 at byte address 0: annexb_mode
//
// Each byte request is registered on entry and processed by the parse core once the
// result register is free or being emptied; the state update and the result are worked
// out combinationally, so one byte is taken every clock while m_axis does not stall.
// The result of the byte ending the unit is registered and then valid on m_axis.
// Reset is synchronous and active low; it leaves the parser idle and
// annexb_mode at zero. While a result is held back by m_axis_tready, one more
// byte is still taken into the input register; after that s_axis stalls.
//
module obu_header_and_size_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,   // [0] start_of_unit
    input  logic        s_axis_tlast,   // end_of_data

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] status, [5:2] OBU type, [6] extension flag, [7] size flag,
    // [10:8] temporal layer, [12:11] spatial layer, [14:13] header_size,
    // [46:15] payload length, [50:47] bytes consumed, [55:51] zero
    output logic [55:0] m_axis_tdata,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ohsp_pkg::*;

    // Configuration register; sampled by the core when a unit starts.
    logic        r_annexb;

    // Input register stage.
    logic        r_in_valid, n_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_sou;
    logic        r_in_eod;

    // Result register stage.
    logic        r_out_valid, n_out_valid;
    t_result     r_out;

    logic        s_accept;
    logic        advance;
    logic        core_emit;
    t_result     core_result;
    logic        reg_hit;

    // The held byte moves through the core when the result register is free
    // or is being emptied in this cycle.
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign n_in_valid  = s_accept ? 1'b1 : (advance ? 1'b0 : r_in_valid);
    assign n_out_valid = (advance && core_emit) ? 1'b1 :
                         (m_axis_tready ? 1'b0 : r_out_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_byte <= s_axis_tdata;
            r_in_sou  <= s_axis_tuser[0];
            r_in_eod  <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && core_emit) begin
            r_out <= core_result;
        end
    end

    ohsp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_annexb (r_annexb),
        .i_byte   (r_in_byte),
        .i_sou    (r_in_sou),
        .i_eod    (r_in_eod),
        .o_emit   (core_emit),
        .o_result (core_result)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0,
                            r_out.used_len,
                            r_out.body_len,
                            r_out.header_size,
                            r_out.slayer,
                            r_out.tlayer,
                            r_out.size_present,
                            r_out.ext_present,
                            r_out.obu_kind,
                            r_out.status};

    // APB register access. Registers are word aligned; bits [1:0] of the
    // address are not decoded.
    assign pready  = 1'b1;
    assign reg_hit = (32'(paddr[2]) == REG_ANNEXB_MODE);
    assign prdata  = reg_hit ? {31'd0, r_annexb} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_annexb <= 1'b0;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_annexb <= pwdata[0];
        end
    end

    // A failed unit reports no sizes.
    a_err_no_sizes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.status != ST_OK)) |->
        ((r_out.header_size == 2'd0) && (r_out.body_len == 32'd0) &&
         (r_out.used_len == 4'd0)))
        else $error("sizes reported on a failed unit");

    // A good unit has a one or two byte header and a length field of at least one byte.
    a_ok_sizes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.status == ST_OK)) |->
        (((r_out.header_size == 2'd1) || (r_out.header_size == 2'd2)) &&
         (r_out.used_len > 4'(r_out.header_size))))
        else $error("bad sizes on a good unit");

    // The input side only stalls when both stages are full and the output waits.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_valid && r_out_valid && !m_axis_tready))
        else $error("input stalled without cause");

    // A waiting result is never overwritten.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |-> !advance)
        else $error("result register overwritten");

endmodule
